>>> rtl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// shared constants, codes and types of the command slot ring tracker
// ----------------------------------------------------------------------------
package cst_pkg;

  // fixed field widths
  localparam int unsigned CI_W   = 32;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned CFG_W  = 6;

  // default ring capacity and register reset
  localparam int unsigned MAX_SLOTS      = 32;
  localparam int unsigned SLOT_COUNT_RST = 32;

  // front-to-back command queue
  localparam int unsigned QUEUE_DEPTH = 2;

  // register port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic        REG_SLOT_COUNT = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_ISSUED   = 2'd0,
    KIND_RESEND   = 2'd1,
    KIND_RETIRED  = 2'd2,
    KIND_REJECTED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_ISSUE        = 2'd0,
    OP_COMPLETE     = 2'd1,
    OP_COMPLETE_ERR = 2'd2
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [CI_W-1:0] ci;
  } cmd_t;

endpackage

>>> rtl/cst_if.sv
// ----------------------------------------------------------------------------
// cst_in_if / cst_out_if
// valid/ready channels for command items and tracker results
// ----------------------------------------------------------------------------
interface cst_in_if;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [cst_pkg::CI_W-1:0] ci_snapshot;
  logic                     port_error;

  modport source (output valid, func, ci_snapshot, port_error, input ready);
  modport sink   (input valid, func, ci_snapshot, port_error, output ready);
endinterface

interface cst_out_if;
  logic                       valid;
  logic                       ready;
  logic [cst_pkg::KIND_W-1:0] kind;
  logic [cst_pkg::SLOT_W-1:0] slot;
  logic [cst_pkg::CI_W-1:0]   ci_mask;
  logic                       status;
  logic                       last;

  modport source (output valid, kind, slot, ci_mask, status, last, input ready);
  modport sink   (input valid, kind, slot, ci_mask, status, last, output ready);
endinterface

>>> rtl/cst_front.sv
// ----------------------------------------------------------------------------
// cst_front
// accepts command items, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module cst_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  cst_in_if.sink        req_i,
  output logic          cmd_valid_o,
  output cst_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);

  localparam int unsigned QD  = cst_pkg::QUEUE_DEPTH;
  localparam int unsigned QA  = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned QCW = $clog2(QD + 1);

  cst_pkg::cmd_t mem_q [QD];
  logic [QA-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QA-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] cnt_q, cnt_d;

  cst_pkg::cmd_t cls;
  logic          push;
  logic          pop;

  // classify
  always_comb begin
    cls.ci = req_i.ci_snapshot;
    if (!req_i.func) begin
      cls.op = cst_pkg::OP_ISSUE;
    end else if (req_i.port_error) begin
      cls.op = cst_pkg::OP_COMPLETE_ERR;
    end else begin
      cls.op = cst_pkg::OP_COMPLETE;
    end
  end

  assign req_i.ready = (cnt_q != QCW'(QD));
  assign push        = req_i.valid && req_i.ready;
  assign pop         = cmd_pop_i && (cnt_q != '0);
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QA'(QD - 1)) ? '0 : wr_ptr_q + QA'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QA'(QD - 1)) ? '0 : rd_ptr_q + QA'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

>>> rtl/cst_back.sv
// ----------------------------------------------------------------------------
// cst_back
// slot ring state and the sequencer that issues, searches and retires slots
// ----------------------------------------------------------------------------
module cst_back #(
  parameter int unsigned MAX_SLOTS = cst_pkg::MAX_SLOTS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [$clog2(MAX_SLOTS + 1)-1:0]   ring_n_i,
  input  logic                               cmd_valid_i,
  input  cst_pkg::cmd_t                      cmd_i,
  output logic                               cmd_pop_o,
  cst_out_if.source                          rsp_o
);

  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned PTR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESEND,
    ST_RETIRE
  } state_e;

  state_e                 state_q, state_d;
  logic [MAX_SLOTS-1:0]   busy_q, busy_d;
  logic [PTR_W-1:0]       rptr_q, rptr_d;
  logic [PTR_W-1:0]       iptr_q, iptr_d;
  logic [CNT_W-1:0]       outst_q, outst_d;
  logic [PTR_W-1:0]       scan_q, scan_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [MAX_SLOTS-1:0]   ci_q, ci_d;
  logic [MAX_SLOTS-1:0]   resend_q, resend_d;
  logic                   fail_q, fail_d;
  logic [PTR_W-1:0]       failed_q, failed_d;

  logic                        out_valid_q, out_valid_d;
  cst_pkg::kind_e              out_kind_q, out_kind_d;
  logic [cst_pkg::SLOT_W-1:0]  out_slot_q, out_slot_d;
  logic [cst_pkg::CI_W-1:0]    out_mask_q, out_mask_d;
  logic                        out_status_q, out_status_d;
  logic                        out_last_q, out_last_d;

  logic                 out_free;
  logic                 out_load;
  logic [PTR_W-1:0]     rptr_nxt;
  logic [MAX_SLOTS-1:0] iss_mask;
  logic                 reject;

  // next slot around the ring, a pointer past the ring end wraps to zero
  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                           input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] q;
    q = CNT_W'(p) + CNT_W'(1);
    return (q >= n) ? '0 : q[PTR_W-1:0];
  endfunction

  assign out_free = !out_valid_q || rsp_o.ready;
  assign rptr_nxt = adv(rptr_q, ring_n_i);
  assign reject   = (outst_q >= ring_n_i) || busy_q[iptr_q];

  always_comb begin
    iss_mask         = '0;
    iss_mask[iptr_q] = 1'b1;
  end

  always_comb begin
    state_d      = state_q;
    busy_d       = busy_q;
    rptr_d       = rptr_q;
    iptr_d       = iptr_q;
    outst_d      = outst_q;
    scan_d       = scan_q;
    cnt_d        = cnt_q;
    ci_d         = ci_q;
    resend_d     = resend_q;
    fail_d       = fail_q;
    failed_d     = failed_q;
    cmd_pop_o    = 1'b0;
    out_load     = 1'b0;
    out_kind_d   = out_kind_q;
    out_slot_d   = out_slot_q;
    out_mask_d   = out_mask_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            cst_pkg::OP_ISSUE: begin
              if (out_free) begin
                cmd_pop_o    = 1'b1;
                out_load     = 1'b1;
                out_status_d = 1'b0;
                out_last_d   = 1'b1;
                if (reject) begin
                  out_kind_d = cst_pkg::KIND_REJECTED;
                  out_slot_d = '0;
                  out_mask_d = '0;
                end else begin
                  busy_d[iptr_q] = 1'b1;
                  out_kind_d     = cst_pkg::KIND_ISSUED;
                  out_slot_d     = cst_pkg::SLOT_W'(iptr_q);
                  out_mask_d     = cst_pkg::CI_W'(iss_mask);
                  iptr_d         = adv(iptr_q, ring_n_i);
                  outst_d        = outst_q + CNT_W'(1);
                end
              end
            end
            cst_pkg::OP_COMPLETE: begin
              cmd_pop_o = 1'b1;
              ci_d      = cmd_i.ci[MAX_SLOTS-1:0];
              fail_d    = 1'b0;
              if (busy_q[rptr_q] && !cmd_i.ci[rptr_q]) begin
                state_d = ST_RETIRE;
              end
            end
            cst_pkg::OP_COMPLETE_ERR: begin
              cmd_pop_o = 1'b1;
              ci_d      = cmd_i.ci[MAX_SLOTS-1:0];
              fail_d    = 1'b0;
              scan_d    = rptr_q;
              cnt_d     = '0;
              resend_d  = '0;
              state_d   = ST_SEARCH;
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end

      // oldest pending slot is the one that failed
      ST_SEARCH: begin
        if (ci_q[scan_q]) begin
          fail_d       = 1'b1;
          failed_d     = scan_q;
          ci_d[scan_q] = 1'b0;
          scan_d       = rptr_q;
          cnt_d        = '0;
          state_d      = ST_RESEND;
        end else if (cnt_q == ring_n_i - CNT_W'(1)) begin
          scan_d  = rptr_q;
          cnt_d   = '0;
          state_d = ST_RESEND;
        end else begin
          scan_d = adv(scan_q, ring_n_i);
          cnt_d  = cnt_q + CNT_W'(1);
        end
      end

      // collect still-pending busy slots in ring order
      ST_RESEND: begin
        if ((cnt_q == ring_n_i) || !busy_q[scan_q]) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_kind_d   = cst_pkg::KIND_RESEND;
            out_slot_d   = '0;
            out_mask_d   = cst_pkg::CI_W'(resend_q);
            out_status_d = 1'b0;
            out_last_d   = !busy_q[rptr_q] || resend_q[rptr_q];
            ci_d         = resend_q;
            state_d      = out_last_d ? ST_IDLE : ST_RETIRE;
          end
        end else begin
          resend_d[scan_q] = ci_q[scan_q];
          scan_d           = adv(scan_q, ring_n_i);
          cnt_d            = cnt_q + CNT_W'(1);
        end
      end

      ST_RETIRE: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_kind_d     = cst_pkg::KIND_RETIRED;
          out_slot_d     = cst_pkg::SLOT_W'(rptr_q);
          out_mask_d     = '0;
          out_status_d   = fail_q && (failed_q == rptr_q);
          // single-slot ring revisits the slot just cleared
          out_last_d     = (rptr_nxt == rptr_q) || !busy_q[rptr_nxt] || ci_q[rptr_nxt];
          busy_d[rptr_q] = 1'b0;
          rptr_d         = rptr_nxt;
          outst_d        = (outst_q != '0) ? outst_q - CNT_W'(1) : outst_q;
          if (out_last_d) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = out_load ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      busy_q       <= '0;
      rptr_q       <= '0;
      iptr_q       <= '0;
      outst_q      <= '0;
      scan_q       <= '0;
      cnt_q        <= '0;
      ci_q         <= '0;
      resend_q     <= '0;
      fail_q       <= 1'b0;
      failed_q     <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= cst_pkg::KIND_ISSUED;
      out_slot_q   <= '0;
      out_mask_q   <= '0;
      out_status_q <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      busy_q       <= busy_d;
      rptr_q       <= rptr_d;
      iptr_q       <= iptr_d;
      outst_q      <= outst_d;
      scan_q       <= scan_d;
      cnt_q        <= cnt_d;
      ci_q         <= ci_d;
      resend_q     <= resend_d;
      fail_q       <= fail_d;
      failed_q     <= failed_d;
      out_valid_q  <= out_valid_d;
      out_kind_q   <= out_kind_d;
      out_slot_q   <= out_slot_d;
      out_mask_q   <= out_mask_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.kind    = out_kind_q;
  assign rsp_o.slot    = out_slot_q;
  assign rsp_o.ci_mask = out_mask_q;
  assign rsp_o.status  = out_status_q;
  assign rsp_o.last    = out_last_q;

endmodule

>>> rtl/command_slot_ring_tracker.sv
// ----------------------------------------------------------------------------
// command_slot_ring_tracker
// command slot ring of one storage port: issue, error recovery and retirement
// ----------------------------------------------------------------------------
// Command items enter on req_i and are queued two deep by the front end, so
// a new item is taken while the back end still works or a result waits on
// rsp_o. The back end handles one item at a time and touches one slot per
// cycle. An issue leaves as a single transfer (issued, or rejected when the
// ring is full or the next slot is still busy). A completion without error
// retires its slots one by one and gives no transfer when nothing retires.
// A completion with a port error adds the failed-slot search and the walk
// over busy slots that builds the resend mask before the resend transfer and
// the retirements. The back-end sequencer sets the rate; a stalled rsp_o
// stalls it, and the queue then fills and drops req_i.ready. The last flag
// marks the final transfer of each item. The user must write slot_count over
// the APB port only while the block is idle; the block does not enforce it.
// 0 acts as 1 and values above MAX_SLOTS act as MAX_SLOTS.
// ----------------------------------------------------------------------------
module command_slot_ring_tracker #(
  parameter int unsigned MAX_SLOTS = cst_pkg::MAX_SLOTS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cst_in_if.sink                       req_i,
  cst_out_if.source                    rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cst_pkg::APB_AW-1:0]   paddr,
  input  logic [cst_pkg::APB_DW-1:0]   pwdata,
  output logic [cst_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);

  // configuration register
  logic [cst_pkg::CFG_W-1:0] slot_count_q, slot_count_d;
  logic                      reg_hit;
  logic                      reg_wr;

  // queue between front and back ends
  logic          cmd_valid;
  cst_pkg::cmd_t cmd;
  logic          cmd_pop;

  // effective ring size
  logic [CNT_W-1:0] ring_n;

  // word index select, byte lanes ignored
  assign reg_hit = (paddr[cst_pkg::APB_AW-1] == cst_pkg::REG_SLOT_COUNT);
  assign reg_wr  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? cst_pkg::APB_DW'(slot_count_q) : '0;

  assign slot_count_d = reg_wr ? pwdata[cst_pkg::CFG_W-1:0] : slot_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= cst_pkg::CFG_W'(cst_pkg::SLOT_COUNT_RST);
    end else begin
      slot_count_q <= slot_count_d;
    end
  end

  // clamp the written count into 1..MAX_SLOTS
  always_comb begin
    if (slot_count_q == '0) begin
      ring_n = CNT_W'(1);
    end else if (slot_count_q > cst_pkg::CFG_W'(MAX_SLOTS)) begin
      ring_n = CNT_W'(MAX_SLOTS);
    end else begin
      ring_n = CNT_W'(slot_count_q);
    end
  end

  // front end: accept, classify, queue
  cst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // back end: slot state, search and retire sequencer, result register
  cst_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ring_n_i    (ring_n),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .rsp_o       (rsp_o)
  );

endmodule

>>> rtl/cst_checker.sv
// ----------------------------------------------------------------------------
// cst_checker
// result-side checks of the command slot ring tracker, bound to the top level
// ----------------------------------------------------------------------------
module cst_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rsp_valid_i,
  input  logic                       rsp_ready_i,
  input  logic [cst_pkg::KIND_W-1:0] rsp_kind_i,
  input  logic [cst_pkg::SLOT_W-1:0] rsp_slot_i,
  input  logic [cst_pkg::CI_W-1:0]   rsp_ci_mask_i,
  input  logic                       rsp_status_i,
  input  logic                       rsp_last_i
);

  logic xfer;
  logic burst_q;
  logic fail_seen_q;

  assign xfer = rsp_valid_i && rsp_ready_i;

  // inside a multi-transfer item until its last transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q     <= 1'b0;
      fail_seen_q <= 1'b0;
    end else if (xfer) begin
      burst_q     <= !rsp_last_i;
      fail_seen_q <= rsp_last_i ? 1'b0 : (fail_seen_q || rsp_status_i);
    end
  end

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_kind_i) &&
      $stable(rsp_slot_i) && $stable(rsp_ci_mask_i) && $stable(rsp_status_i) &&
      $stable(rsp_last_i))
    else $error("result changed while stalled");

  // issue mask is the one-hot of the issued slot
  a_issue_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_kind_i == cst_pkg::KIND_ISSUED) |->
      $onehot(rsp_ci_mask_i) && rsp_ci_mask_i[rsp_slot_i] && !rsp_status_i)
    else $error("issue mask does not match slot");

  // after the first transfer of an item only retirements follow
  a_burst_retire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && burst_q |-> (rsp_kind_i == cst_pkg::KIND_RETIRED))
    else $error("non-retire transfer inside a completion");

  // at most one failed slot per completion
  a_one_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && rsp_status_i |-> !fail_seen_q)
    else $error("second failed slot in one completion");

endmodule

bind command_slot_ring_tracker cst_checker u_cst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_kind_i    (rsp_o.kind),
  .rsp_slot_i    (rsp_o.slot),
  .rsp_ci_mask_i (rsp_o.ci_mask),
  .rsp_status_i  (rsp_o.status),
  .rsp_last_i    (rsp_o.last)
);
